>>> sv/bid_pkg.sv
// bid_pkg: shared widths and types of the bareiss determinant block
// no dependencies; imported by the channel interfaces and all modules
`default_nettype none
package bid_pkg;
	localparam int SIZE_W = 4;
	localparam int ELEM_W = 7;
	localparam int WORD_W = 64;
	localparam int PROD_W = 128;
	localparam int DET_W  = 62;

	// one loaded matrix waiting for elimination
	typedef struct packed {
		logic [SIZE_W-1:0] n;
	} job_t;
endpackage
`default_nettype wire

>>> sv/bid_if.sv
// bid_elem_if / bid_res_if: valid-ready channels for matrix entries and results
// depends on bid_pkg
`default_nettype none
interface bid_elem_if import bid_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] element;
	modport source (output valid, output element, input ready);
	modport sink (input valid, input element, output ready);
endinterface

interface bid_res_if import bid_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DET_W-1:0] determinant;
	logic                    no_pivot;
	modport source (output valid, output determinant, output no_pivot, input ready);
	modport sink (input valid, input determinant, input no_pivot, output ready);
endinterface
`default_nettype wire

>>> sv/bid_front.sv
// bid_front: size register, entry intake and store addressing, job hand-off
// depends on bid_pkg and bid_elem_if
`default_nettype none
module bid_front import bid_pkg::*; #(
	parameter int MAX_SIZE = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [SIZE_W-1:0]     cfg_data,
	output logic      [SIZE_W-1:0]     size,
	bid_elem_if.sink                   elem,
	input  wire logic                  busy,
	output logic                       job_push,
	output job_t                       job,
	output logic                       wr_en,
	output logic [2*$clog2(MAX_SIZE)-1:0] wr_addr,
	output logic [WORD_W-1:0]          wr_data
);
	localparam int IW = $clog2(MAX_SIZE);

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] row_q, col_q;
	logic [SIZE_W-1:0] n_eff;
	logic              accept, col_last, row_last;

	always_comb begin
		if (size_q == '0) begin
			n_eff = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			n_eff = SIZE_W'(MAX_SIZE);
		end else begin
			n_eff = size_q;
		end
	end

	assign elem.ready = !busy;
	assign accept     = elem.valid && elem.ready;
	assign col_last   = (col_q + SIZE_W'(1)) == n_eff;
	assign row_last   = (row_q + SIZE_W'(1)) == n_eff;

	assign size     = size_q;
	assign wr_en    = accept;
	assign wr_addr  = {row_q[IW-1:0], col_q[IW-1:0]};
	assign wr_data  = {{(WORD_W-ELEM_W){elem.element[ELEM_W-1]}}, elem.element};
	assign job_push = accept && col_last && row_last;
	assign job.n    = n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(8);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_data;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + SIZE_W'(1);
			end else begin
				col_q <= col_q + SIZE_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/bid_queue.sv
// bid_queue: two-entry job queue between intake and elimination
// depends on bid_pkg
`default_nettype none
module bid_queue import bid_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      valid,
	input  wire logic pop,
	output job_t      head,
	output logic      empty
);
	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign do_push = push && (cnt_q != 2'd2);
	assign do_pop  = pop && (cnt_q != 2'd0);
	assign valid   = cnt_q != 2'd0;
	assign empty   = cnt_q == 2'd0;
	assign head    = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				slot_q[wp_q] <= push_job;
				wp_q         <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/bid_mul.sv
// bid_mul: signed 64x64 -> 128 multiplier, one 32x32 partial product a cycle
// depends on bid_pkg
`default_nettype none
module bid_mul import bid_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] op_a,
	input  wire logic [WORD_W-1:0] op_b,
	output logic                   done,
	output logic [PROD_W-1:0]      prod
);
	logic [WORD_W-1:0] ma_q, mb_q;
	logic              neg_q, run_q, done_q;
	logic [2:0]        cnt_q, idx;
	logic [63:0]       pp_q;
	logic [PROD_W-1:0] acc_q;
	logic [31:0]       limb_a, limb_b;
	logic [6:0]        sh;

	assign limb_a = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign limb_b = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign idx    = cnt_q - 3'd1;
	// weight of the partial product taken last cycle
	assign sh     = {idx[1] & idx[0], idx[1] ^ idx[0], 5'b0};
	assign done   = done_q;
	assign prod   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			ma_q   <= '0;
			mb_q   <= '0;
			pp_q   <= '0;
			acc_q  <= '0;
		end else if (start) begin
			ma_q   <= op_a[63] ? (WORD_W'(0) - op_a) : op_a;
			mb_q   <= op_b[63] ? (WORD_W'(0) - op_b) : op_b;
			neg_q  <= op_a[63] ^ op_b[63];
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
			acc_q  <= '0;
		end else if (run_q) begin
			pp_q <= limb_a * limb_b;
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
				acc_q <= acc_q + ({64'b0, pp_q} << sh);
			end
			if (cnt_q == 3'd5) begin
				if (neg_q) begin
					acc_q <= PROD_W'(0) - acc_q;
				end
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q + 3'd1;
		end else begin
			done_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> sv/bid_back.sv
// bid_back: matrix store and bareiss elimination sequencer with output register
// depends on bid_pkg, bid_res_if and bid_mul
`default_nettype none
module bid_back import bid_pkg::*; #(
	parameter int MAX_SIZE = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      job_valid,
	input  job_t                           job,
	output logic                           job_pop,
	input  wire logic                      f_wr_en,
	input  wire logic [2*$clog2(MAX_SIZE)-1:0] f_wr_addr,
	input  wire logic [WORD_W-1:0]         f_wr_data,
	output logic                           idle,
	bid_res_if.source                      res
);
	localparam int IW = $clog2(MAX_SIZE);
	localparam int AW = 2 * IW;

	typedef enum logic [19:0] {
		S_IDLE     = 20'h00001,
		S_SRCH_RD  = 20'h00002,
		S_SRCH_CHK = 20'h00004,
		S_ROW_RD   = 20'h00008,
		S_IK_CAP   = 20'h00010,
		S_KJ_RD    = 20'h00020,
		S_IJ_RD    = 20'h00040,
		S_IJ_CAP   = 20'h00080,
		S_MUL1     = 20'h00100,
		S_MUL2     = 20'h00200,
		S_SHIFT    = 20'h00400,
		S_MUL3     = 20'h00800,
		S_TZ       = 20'h01000,
		S_NEWT_A   = 20'h02000,
		S_NEWT_B   = 20'h04000,
		S_NEWT_C   = 20'h08000,
		S_NEXT     = 20'h10000,
		S_FIN_RD   = 20'h20000,
		S_FIN_CAP  = 20'h40000,
		S_DONE     = 20'h80000
	} state_t;

	state_t state_q;

	logic [WORD_W-1:0] mem [2**AW];
	logic [WORD_W-1:0] rd_q;
	logic [AW-1:0]     rd_addr, wa;
	logic              bk_we, we;
	logic [WORD_W-1:0] wd;

	logic [SIZE_W-1:0] n_q, k_q, p_q, i_q, j_q, nm1;
	logic [IW-1:0]     perm_q [MAX_SIZE];
	logic              flip_q;
	logic [WORD_W-1:0] pk_q, aik_q, akj_q, inv_q, x_q;
	logic signed [WORD_W-1:0] d_q;
	logic [5:0]        t_q;
	logic [2:0]        it_q;
	logic [PROD_W-1:0] p1_q;
	logic signed [PROD_W-1:0] num_q, shifted;

	logic              mul_start, mul_done;
	logic [WORD_W-1:0] mul_a, mul_b;
	logic [PROD_W-1:0] mul_prod;

	logic              ov_q, res_flag_q, flag_q, load_out;
	logic [DET_W-1:0]  res_det_q, det_q;

	assign nm1     = n_q - SIZE_W'(1);
	assign shifted = num_q >>> t_q;
	assign idle    = state_q == S_IDLE;
	assign job_pop = idle && job_valid;

	always_comb begin
		unique case (state_q)
			S_SRCH_RD: rd_addr = {perm_q[p_q[IW-1:0]], k_q[IW-1:0]};
			S_ROW_RD:  rd_addr = {perm_q[i_q[IW-1:0]], k_q[IW-1:0]};
			S_KJ_RD:   rd_addr = {perm_q[k_q[IW-1:0]], j_q[IW-1:0]};
			S_IJ_RD:   rd_addr = {perm_q[i_q[IW-1:0]], j_q[IW-1:0]};
			S_FIN_RD:  rd_addr = {perm_q[nm1[IW-1:0]], nm1[IW-1:0]};
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IJ_CAP: begin
				mul_start = 1'b1;
				mul_a     = rd_q;
				mul_b     = pk_q;
			end
			S_MUL1: begin
				mul_start = mul_done;
				mul_a     = aik_q;
				mul_b     = akj_q;
			end
			S_SHIFT: begin
				// exact quotient: shifted numerator times the old pivot's odd-part inverse
				mul_start = 1'b1;
				mul_a     = shifted[WORD_W-1:0];
				mul_b     = inv_q;
			end
			S_NEWT_A: begin
				mul_start = 1'b1;
				mul_a     = d_q;
				mul_b     = x_q;
			end
			S_NEWT_B: begin
				mul_start = mul_done;
				mul_a     = x_q;
				mul_b     = WORD_W'(2) - mul_prod[WORD_W-1:0];
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign bk_we = (state_q == S_MUL3) && mul_done;
	assign we    = f_wr_en || bk_we;
	assign wa    = f_wr_en ? f_wr_addr : {perm_q[i_q[IW-1:0]], j_q[IW-1:0]};
	assign wd    = f_wr_en ? f_wr_data : mul_prod[WORD_W-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	bid_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign load_out        = (state_q == S_DONE) && (!ov_q || res.ready);
	assign res.valid       = ov_q;
	assign res.determinant = det_q;
	assign res.no_pivot    = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= '0;
			k_q        <= '0;
			p_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			flip_q     <= 1'b0;
			t_q        <= '0;
			it_q       <= '0;
			ov_q       <= 1'b0;
			for (int r = 0; r < MAX_SIZE; r++) begin
				perm_q[r] <= IW'(r);
			end
		end else begin
			if (load_out) begin
				ov_q   <= 1'b1;
				det_q  <= res_det_q;
				flag_q <= res_flag_q;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						n_q    <= job.n;
						k_q    <= '0;
						p_q    <= '0;
						flip_q <= 1'b0;
						t_q    <= '0;
						inv_q  <= WORD_W'(1);
						for (int r = 0; r < MAX_SIZE; r++) begin
							perm_q[r] <= IW'(r);
						end
						state_q <= (job.n == SIZE_W'(1)) ? S_FIN_RD : S_SRCH_RD;
					end
				end
				S_SRCH_RD: state_q <= S_SRCH_CHK;
				S_SRCH_CHK: begin
					if (rd_q != '0) begin
						pk_q <= rd_q;
						// row swap through the permutation table
						perm_q[k_q[IW-1:0]] <= perm_q[p_q[IW-1:0]];
						perm_q[p_q[IW-1:0]] <= perm_q[k_q[IW-1:0]];
						flip_q  <= flip_q ^ (p_q != k_q);
						i_q     <= k_q + SIZE_W'(1);
						state_q <= S_ROW_RD;
					end else if ((p_q + SIZE_W'(1)) == n_q) begin
						res_det_q  <= '0;
						res_flag_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						p_q     <= p_q + SIZE_W'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_ROW_RD: begin
					j_q     <= k_q + SIZE_W'(1);
					state_q <= S_IK_CAP;
				end
				S_IK_CAP: begin
					aik_q   <= rd_q;
					state_q <= S_KJ_RD;
				end
				S_KJ_RD: state_q <= S_IJ_RD;
				S_IJ_RD: begin
					akj_q   <= rd_q;
					state_q <= S_IJ_CAP;
				end
				S_IJ_CAP: state_q <= S_MUL1;
				S_MUL1: begin
					if (mul_done) begin
						p1_q    <= mul_prod;
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						num_q   <= p1_q - mul_prod;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: state_q <= S_MUL3;
				S_MUL3: begin
					if (mul_done) begin
						if ((j_q + SIZE_W'(1)) == n_q) begin
							if ((i_q + SIZE_W'(1)) == n_q) begin
								d_q     <= pk_q;
								t_q     <= '0;
								state_q <= S_TZ;
							end else begin
								i_q     <= i_q + SIZE_W'(1);
								state_q <= S_ROW_RD;
							end
						end else begin
							j_q     <= j_q + SIZE_W'(1);
							state_q <= S_KJ_RD;
						end
					end
				end
				S_TZ: begin
					// strip trailing zeros of the new pivot, one bit a cycle
					if (d_q[0]) begin
						x_q     <= d_q;
						it_q    <= '0;
						state_q <= S_NEWT_A;
					end else begin
						d_q <= d_q >>> 1;
						t_q <= t_q + 6'd1;
					end
				end
				S_NEWT_A: state_q <= S_NEWT_B;
				S_NEWT_B: begin
					if (mul_done) begin
						state_q <= S_NEWT_C;
					end
				end
				S_NEWT_C: begin
					if (mul_done) begin
						x_q <= mul_prod[WORD_W-1:0];
						if (it_q == 3'd4) begin
							state_q <= S_NEXT;
						end else begin
							it_q    <= it_q + 3'd1;
							state_q <= S_NEWT_A;
						end
					end
				end
				S_NEXT: begin
					inv_q <= x_q;
					k_q   <= k_q + SIZE_W'(1);
					p_q   <= k_q + SIZE_W'(1);
					state_q <= ((k_q + SIZE_W'(2)) == n_q) ? S_FIN_RD : S_SRCH_RD;
				end
				S_FIN_RD: state_q <= S_FIN_CAP;
				S_FIN_CAP: begin
					res_det_q  <= flip_q ? DET_W'(WORD_W'(0) - rd_q) : rd_q[DET_W-1:0];
					res_flag_q <= 1'b0;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sv/bareiss_integer_determinant.sv
// bareiss_integer_determinant: entries load one per cycle while the engine is idle;
// after the last entry the engine runs each update on the shared 32x32 multiplier
// and computes a pivot inverse per column, then the result sits in an output
// register; the next matrix is held off until the engine is idle
// arst_n clears control state and sets matrix_size to 8; the store is not cleared
`default_nettype none
module bareiss_integer_determinant import bid_pkg::*; #(
	parameter int MAX_SIZE = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	bid_elem_if.sink         elem_ch,
	bid_res_if.source        res_ch
);
	localparam int AW = 2 * $clog2(MAX_SIZE);

	logic              cfg_we, busy, push, pop, q_valid, q_empty, back_idle;
	logic [SIZE_W-1:0] size;
	job_t              push_job, head;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);
	assign prdata = (paddr == 3'd0) ? {{(32-SIZE_W){1'b0}}, size} : 32'd0;
	assign busy   = !q_empty || !back_idle;

	bid_front #(.MAX_SIZE(MAX_SIZE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (pwdata[SIZE_W-1:0]),
		.size     (size),
		.elem     (elem_ch),
		.busy     (busy),
		.job_push (push),
		.job      (push_job),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	bid_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.valid    (q_valid),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	bid_back #(.MAX_SIZE(MAX_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (head),
		.job_pop   (pop),
		.f_wr_en   (wr_en),
		.f_wr_addr (wr_addr),
		.f_wr_data (wr_data),
		.idle      (back_idle),
		.res       (res_ch)
	);
endmodule
`default_nettype wire
